// ----- sv/csv_line_field_splitter_defines.svh -----
// Assertion macros for the CSV line field splitter checker.
// No dependencies; included by files that hold assertions.
`ifndef CSV_LINE_FIELD_SPLITTER_DEFINES_SVH
`define CSV_LINE_FIELD_SPLITTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CSVLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csvls assertion failed");

// Next-cycle implication, disabled during reset.
`define CSVLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csvls assertion failed");

`endif

// ----- sv/csvls_pkg.sv -----
// Shared types and constants for the CSV line field splitter.
// No dependencies.
package csvls_pkg;

    localparam int unsigned ADDR_W = 3;

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_PLAIN  = 3'd1;
    localparam logic [2:0] PH_QUOTED = 3'd2;
    localparam logic [2:0] PH_QPEND  = 3'd3;
    localparam logic [2:0] PH_CLOSED = 3'd4;
    localparam logic [2:0] PH_DROP   = 3'd5;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_FIELD = 2'd1;
    localparam logic [1:0] KIND_LAST  = 2'd2;

    localparam logic [7:0] MAX_FIELD_RESET = 8'd255;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
    } token_t;

    typedef struct packed {
        logic   push;
        token_t tok;
    } push_t;

endpackage

// ----- sv/csvls_apb_regs.sv -----
// APB register block: holds max_field_bytes.
// Depends on csvls_pkg.
module csvls_apb_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [csvls_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [7:0]                    max_field
);

    logic [7:0] max_field_reg;
    logic       wr_en;

    assign wr_en     = psel && penable && pwrite && (paddr[csvls_pkg::ADDR_W-1] == 1'b0);
    assign pready    = 1'b1;
    assign prdata    = (paddr[csvls_pkg::ADDR_W-1] == 1'b0) ? {24'd0, max_field_reg} : 32'd0;
    assign max_field = max_field_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_field_reg <= csvls_pkg::MAX_FIELD_RESET;
        end
        else if (wr_en)
        begin
            max_field_reg <= pwdata[7:0];
        end
    end

endmodule

// ----- sv/csvls_parser.sv -----
// Input register and parse state; one step of the field splitter per byte.
// Depends on csvls_pkg.
module csvls_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          char_in,
    input  logic                line_done,
    input  logic [7:0]          max_field,
    input  logic                out_ready,
    output csvls_pkg::push_t    push
);

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_char_reg;
    logic       s1_done_reg;
    logic [2:0] phase_reg;
    logic [2:0] phase_next;
    logic [7:0] len_reg;
    logic [7:0] len_next;
    logic       full;
    logic       accept;
    logic       fire;
    logic       emit;
    logic [1:0] kind;
    logic [7:0] ch;

    assign in_stall = s1_valid_reg && !out_ready;
    assign accept   = in_valid && !in_stall;
    assign fire     = s1_valid_reg && out_ready;
    assign full     = len_reg >= max_field;

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    // one parse step
    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        emit       = 1'b0;
        kind       = csvls_pkg::KIND_BYTE;
        ch         = 8'd0;
        if (s1_done_reg)
        begin
            phase_next = csvls_pkg::PH_START;
            len_next   = 8'd0;
            emit       = (phase_reg != csvls_pkg::PH_DROP);
            kind       = csvls_pkg::KIND_LAST;
        end
        else
        begin
            unique case (phase_reg)
                csvls_pkg::PH_START, csvls_pkg::PH_PLAIN:
                begin
                    if (phase_reg == csvls_pkg::PH_START && s1_char_reg == csvls_pkg::CH_QUOTE)
                    begin
                        phase_next = csvls_pkg::PH_QUOTED;
                        len_next   = 8'd0;
                    end
                    else if (s1_char_reg == csvls_pkg::CH_COMMA)
                    begin
                        phase_next = csvls_pkg::PH_START;
                        len_next   = 8'd0;
                        emit       = 1'b1;
                        kind       = csvls_pkg::KIND_FIELD;
                    end
                    else if (full)
                    begin
                        phase_next = csvls_pkg::PH_DROP;
                        len_next   = 8'd0;
                        emit       = 1'b1;
                        kind       = csvls_pkg::KIND_LAST;
                    end
                    else
                    begin
                        phase_next = csvls_pkg::PH_PLAIN;
                        len_next   = len_reg + 8'd1;
                        emit       = 1'b1;
                        ch         = s1_char_reg;
                    end
                end
                csvls_pkg::PH_QUOTED:
                begin
                    if (s1_char_reg == csvls_pkg::CH_QUOTE)
                    begin
                        phase_next = full ? csvls_pkg::PH_CLOSED : csvls_pkg::PH_QPEND;
                    end
                    else if (!full)
                    begin
                        len_next = len_reg + 8'd1;
                        emit     = 1'b1;
                        ch       = s1_char_reg;
                    end
                    else if (s1_char_reg == csvls_pkg::CH_COMMA)
                    begin
                        phase_next = csvls_pkg::PH_START;
                        len_next   = 8'd0;
                        emit       = 1'b1;
                        kind       = csvls_pkg::KIND_FIELD;
                    end
                    else
                    begin
                        phase_next = csvls_pkg::PH_DROP;
                        len_next   = 8'd0;
                        emit       = 1'b1;
                        kind       = csvls_pkg::KIND_LAST;
                    end
                end
                csvls_pkg::PH_QPEND, csvls_pkg::PH_CLOSED:
                begin
                    if (phase_reg == csvls_pkg::PH_QPEND && s1_char_reg == csvls_pkg::CH_QUOTE
                        && !full)
                    begin
                        phase_next = csvls_pkg::PH_QUOTED;
                        len_next   = len_reg + 8'd1;
                        emit       = 1'b1;
                        ch         = s1_char_reg;
                    end
                    else if (s1_char_reg == csvls_pkg::CH_COMMA)
                    begin
                        phase_next = csvls_pkg::PH_START;
                        len_next   = 8'd0;
                        emit       = 1'b1;
                        kind       = csvls_pkg::KIND_FIELD;
                    end
                    else
                    begin
                        phase_next = csvls_pkg::PH_DROP;
                        len_next   = 8'd0;
                        emit       = 1'b1;
                        kind       = csvls_pkg::KIND_LAST;
                    end
                end
                default:
                begin
                    phase_next = csvls_pkg::PH_DROP;
                end
            endcase
        end
    end

    assign push.push     = fire && emit;
    assign push.tok.kind = kind;
    assign push.tok.ch   = ch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            phase_reg    <= csvls_pkg::PH_START;
            len_reg      <= 8'd0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (fire)
            begin
                phase_reg <= phase_next;
                len_reg   <= len_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_char_reg <= char_in;
            s1_done_reg <= line_done;
        end
    end

endmodule

// ----- sv/csvls_out_reg.sv -----
// Result register for the output channel.
// Depends on csvls_pkg.
module csvls_out_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  csvls_pkg::push_t    push,
    output logic                out_ready,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          token_kind,
    output logic [7:0]          char_out
);

    logic              valid_reg;
    logic              valid_next;
    csvls_pkg::token_t tok_reg;

    assign out_ready  = !valid_reg || !out_stall;
    assign out_valid  = valid_reg;
    assign token_kind = tok_reg.kind;
    assign char_out   = tok_reg.ch;

    always_comb
    begin
        if (push.push)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            tok_reg <= push.tok;
        end
    end

endmodule

// ----- sv/csv_line_field_splitter.sv -----
// CSV line field splitter: one byte per transfer in, zero or one token per byte out.
// Input channel: in_valid/in_stall with char_in and line_done; a line_done transfer
// ends the line and char_in is ignored on it.
// Output channel: out_valid/out_stall with token_kind (field byte, field end, record
// end) and char_out (the byte for field bytes, else zero).
// Configuration: APB register 0 (address 0) holds max_field_bytes, reset 255; write
// only while no transfer is in flight.
// A byte passes the input register, then the result register, before its token shows
// on out_valid; the parse step between them is combinational. Throughput: one byte per
// cycle while out_stall does not hold a token, set by the combinational parse step.
// Bytes that produce no token (opening and closing quotes, dropped tail of a line)
// still pass through the input register like any other byte.
// When out_stall holds a token, the next byte may still be taken into the input
// register; after that in_stall rises until the result register frees up.
// Reset clears the parse state to field start, empties both registers and sets
// the field limit to 255.
// Depends on csvls_pkg, csvls_apb_regs, csvls_parser and csvls_out_reg.
module csv_line_field_splitter
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    char_in,
    input  logic                          line_done,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    token_kind,
    output logic [7:0]                    char_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [csvls_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic             [7:0] max_field;
    logic                   out_ready;
    csvls_pkg::push_t       push;

    csvls_apb_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .max_field (max_field)
    );

    csvls_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_in   (char_in),
        .line_done (line_done),
        .max_field (max_field),
        .out_ready (out_ready),
        .push      (push)
    );

    csvls_out_reg u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .token_kind (token_kind),
        .char_out   (char_out)
    );

endmodule

// ----- sv/csvls_checker.sv -----
// Port-level checker for the CSV line field splitter, bound to the top level.
// Depends on csvls_pkg and csv_line_field_splitter_defines.svh.
`include "csv_line_field_splitter_defines.svh"

module csvls_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [1:0]                    token_kind,
    input logic [7:0]                    char_out,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [csvls_pkg::ADDR_W-1:0]  paddr,
    input logic [31:0]                   pwdata,
    input logic [31:0]                   prdata,
    input logic                          pready
);

    logic       marker_out;
    logic       out_blocked;
    logic       cfg_write;
    logic [9:0] tok_bits;

    assign marker_out  = out_valid && (token_kind != csvls_pkg::KIND_BYTE);
    assign out_blocked = out_valid && out_stall;
    assign cfg_write   = psel && penable && pwrite && pready && (paddr == '0);
    assign tok_bits    = {token_kind, char_out};

    `CSVLS_ASSERT_NOW(a_kind_legal, clk, rst_n, out_valid, token_kind <= csvls_pkg::KIND_LAST)

    `CSVLS_ASSERT_NOW(a_marker_zero, clk, rst_n, marker_out, char_out == 8'd0)

    `CSVLS_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_blocked)

    `CSVLS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_blocked, out_valid && $stable(tok_bits))

    `CSVLS_ASSERT_NEXT(a_reg_write, clk, rst_n, cfg_write, prdata[7:0] == $past(pwdata[7:0]))

endmodule

bind csv_line_field_splitter csvls_checker u_chk (.*);

// ----- tb/tb_csv_line_field_splitter.sv -----
// Self-checking testbench for csv_line_field_splitter: drives CSV lines byte by byte,
// predicts every token in a small scoreboard class and checks each output transfer.
// Depends on csvls_pkg and the csv_line_field_splitter RTL.
module tb_csv_line_field_splitter;
    import csvls_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_MAX_FIELD = '0;
    localparam int ITEM_TARGET = 1050;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 8;

    class csv_token_scoreboard;
        token_t     pending_tokens[$];
        logic [2:0] phase;
        logic [7:0] field_len;
        logic [7:0] max_bytes;
        int         errors;
        int         checked;

        function new();
            phase = PH_START;
            field_len = '0;
            max_bytes = MAX_FIELD_RESET;
            errors = 0;
            checked = 0;
        endfunction

        function void set_limit(logic [7:0] v);
            max_bytes = v;
        endfunction

        function bit field_full();
            return field_len >= max_bytes;
        endfunction

        function token_t close_field();
            token_t t;
            phase = PH_START;
            field_len = '0;
            t.kind = KIND_FIELD;
            t.ch = '0;
            return t;
        endfunction

        function token_t close_record();
            token_t t;
            phase = PH_DROP;
            field_len = '0;
            t.kind = KIND_LAST;
            t.ch = '0;
            return t;
        endfunction

        function token_t keep(logic [7:0] c);
            token_t t;
            field_len = field_len + 8'd1;
            t.kind = KIND_BYTE;
            t.ch = c;
            return t;
        endfunction

        function token_t plain_char(logic [7:0] c);
            if (c == CH_COMMA)
                return close_field();
            if (field_full())
                return close_record();
            phase = PH_PLAIN;
            return keep(c);
        endfunction

        // Called once per accepted input transfer.
        function void note_byte(logic [7:0] c, logic done);
            token_t t;
            bit     has;
            has = 1'b1;
            t = '0;
            if (done)
            begin
                has = (phase != PH_DROP);
                phase = PH_START;
                field_len = '0;
                t.kind = KIND_LAST;
            end
            else
            begin
                case (phase)
                    PH_START:
                        if (c == CH_QUOTE)
                        begin
                            phase = PH_QUOTED;
                            field_len = '0;
                            has = 1'b0;
                        end
                        else
                            t = plain_char(c);
                    PH_PLAIN:
                        t = plain_char(c);
                    PH_QUOTED:
                        if (field_full())
                        begin
                            if (c == CH_QUOTE)
                            begin
                                phase = PH_CLOSED;
                                has = 1'b0;
                            end
                            else if (c == CH_COMMA)
                                t = close_field();
                            else
                                t = close_record();
                        end
                        else if (c == CH_QUOTE)
                        begin
                            phase = PH_QPEND;
                            has = 1'b0;
                        end
                        else
                            t = keep(c);
                    PH_QPEND:
                        if (c == CH_QUOTE && !field_full())
                        begin
                            phase = PH_QUOTED;
                            t = keep(c);
                        end
                        else if (c == CH_COMMA)
                            t = close_field();
                        else
                            t = close_record();
                    PH_CLOSED:
                        if (c == CH_COMMA)
                            t = close_field();
                        else
                            t = close_record();
                    default:
                    begin
                        phase = PH_DROP;
                        has = 1'b0;
                    end
                endcase
            end
            if (has)
                pending_tokens.push_back(t);
        endfunction

        // Called once per accepted output transfer.
        function void check_token(logic [1:0] kind, logic [7:0] ch);
            token_t want;
            if (pending_tokens.size() == 0)
            begin
                $error("token with no expectation: token_kind %0d char_out %02h", kind, ch);
                errors++;
                return;
            end
            want = pending_tokens.pop_front();
            checked++;
            if (kind !== want.kind)
            begin
                $error("token_kind mismatch: expected %0d, got %0d", want.kind, kind);
                errors++;
            end
            if (ch !== want.ch)
            begin
                $error("char_out mismatch: expected %02h, got %02h", want.ch, ch);
                errors++;
            end
        endfunction
    endclass

    bit                 clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         char_in;
    logic               line_done;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         token_kind;
    logic [7:0]         char_out;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    csv_token_scoreboard sb;
    int idle_pct;
    int stall_pct;
    int cur_limit;
    int items_sent;
    int lines_sent;
    int phases_run;
    int cycles;

    csv_line_field_splitter dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_in    (char_in),
        .line_done  (line_done),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .token_kind (token_kind),
        .char_out   (char_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);

    // Handshake signals are stable at the falling edge; the transfer lands on the next rise.
    always @(negedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_token(token_kind, char_out);

    task automatic send_byte(input logic [7:0] c, input logic done);
        bit took;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        char_in <= c;
        line_done <= done;
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = !in_stall;
            if (took)
                sb.note_byte(c, done);
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic end_line();
        send_byte(8'($urandom), 1'b1);
        lines_sent++;
    endtask

    function automatic logic [7:0] text_byte();
        int         r;
        logic [7:0] b;
        r = $urandom_range(99);
        if (r < 55)
            return 8'($urandom_range(8'h61, 8'h7a));
        if (r < 65)
            return CH_QUOTE;
        do
            b = 8'($urandom);
        while (b == CH_COMMA);
        return b;
    endfunction

    task automatic send_plain(input int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            b = text_byte();
            if (i == 0 && b == CH_QUOTE)
                b = 8'h41;
            send_byte(b, 1'b0);
        end
    endtask

    task automatic send_quoted(input int len, input bit closed);
        logic [7:0] b;
        send_byte(CH_QUOTE, 1'b0);
        for (int i = 0; i < len; i++)
        begin
            b = ($urandom_range(9) == 0) ? CH_COMMA : text_byte();
            send_byte(b, 1'b0);
            if (b == CH_QUOTE)
                send_byte(CH_QUOTE, 1'b0);
        end
        if (closed)
            send_byte(CH_QUOTE, 1'b0);
    endtask

    task automatic send_line();
        int         nf;
        int         len;
        int         style;
        int         max_len;
        logic [7:0] junk;
        nf = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 4);
        max_len = (cur_limit < 12) ? cur_limit + 2 : 10;
        for (int f = 0; f < nf; f++)
        begin
            len = $urandom_range(0, max_len);
            style = $urandom_range(99);
            if (style < 50)
                send_plain(len);
            else if (style < 85)
            begin
                send_quoted(len, 1'b1);
                if ($urandom_range(9) == 0)
                begin
                    junk = text_byte();
                    send_byte(junk, 1'b0);
                end
            end
            else if (style < 92)
                send_quoted(len, 1'b0);
            else
                repeat (len) send_byte(8'($urandom), 1'b0);
            if (f != nf - 1 || $urandom_range(7) == 0)
                send_byte(CH_COMMA, 1'b0);
        end
        end_line();
    endtask

    task automatic write_limit(input logic [7:0] v);
        bit rdy;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_MAX_FIELD;
        pwdata <= {24'($urandom), v};
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            rdy = pready;
            @(posedge clk);
        end
        while (!rdy);
        sb.set_limit(v);
        cur_limit = int'(v);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending_tokens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int start;
        sb = new();
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        char_in <= '0;
        line_done <= 1'b0;
        out_stall <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        idle_pct = 0;
        stall_pct = 0;
        cur_limit = int'(MAX_FIELD_RESET);
        items_sent = 0;
        lines_sent = 0;
        phases_run = 0;
        cycles = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_limit(8'd255);
        // empty line
        end_line();
        // extreme bytes, then trailing comma gives one empty last field
        send_byte(8'h61, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(CH_COMMA, 1'b0);
        end_line();
        // quoted field with a doubled quote and an embedded comma
        send_byte(CH_QUOTE, 1'b0);
        send_byte(8'h78, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_COMMA, 1'b0);
        send_byte(8'h79, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_COMMA, 1'b0);
        end_line();
        // junk after the closing quote ends the record, rest dropped
        send_byte(CH_QUOTE, 1'b0);
        send_byte(8'h7a, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(8'h71, 1'b0);
        send_byte(8'h72, 1'b0);
        end_line();
        // unterminated quote
        send_byte(CH_QUOTE, 1'b0);
        send_byte(8'h75, 1'b0);
        end_line();

        while (items_sent < ITEM_TARGET)
        begin
            wait_idle();
            case (phases_run % 8)
                0: write_limit(8'd255);
                1: write_limit(8'd1);
                2: write_limit(8'd0);
                3: write_limit(8'd2);
                4: write_limit(8'd3);
                5: write_limit(8'($urandom_range(1, 8)));
                6: write_limit(8'($urandom_range(0, 255)));
                default: write_limit(8'd254);
            endcase
            case (phases_run % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 85; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 85; end
                default: begin idle_pct = 9; stall_pct = 9; end
            endcase
            if (phases_run == 0)
            begin
                send_plain(257);
                end_line();
            end
            start = items_sent;
            while (items_sent - start < 40 && items_sent < ITEM_TARGET)
                send_line();
            // leave a field open so the next limit change lands mid-field
            if ($urandom_range(1) == 1)
                send_plain($urandom_range(1, 4));
            phases_run++;
        end
        wait_idle();

        $display("Sent %0d bytes over %0d lines in %0d random phases; %0d tokens checked.",
                 items_sent, lines_sent, phases_run, sb.checked);
        $display("Field limits 0, 1, 2, 3, 254, 255 and random, under four idle/stall mixes.");
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+sv
sv/csvls_pkg.sv
sv/csvls_apb_regs.sv
sv/csvls_parser.sv
sv/csvls_out_reg.sv
sv/csv_line_field_splitter.sv
sv/csvls_checker.sv
tb/tb_csv_line_field_splitter.sv
